// ===== src/dfp_pkg.sv =====
// Package for the spectral divergence-free projector: item structs and datapath widths.
// No dependencies; used by divergence_free_projector_core.
package dfp_pkg;

  // Field widths of one item
  localparam int KW  = 24;  // wavevector component, signed Q12.12
  localparam int IKW = 32;  // inverse squared wavenumber, unsigned Q8.24
  localparam int QW  = 32;  // field part, signed Q16.16

  // Vector shape
  localparam int NumComp = 3;  // x, y, z
  localparam int NumPart = 2;  // real, imaginary

  // Dot product: k*q products and their three-term sum
  localparam int PW  = KW + QW;   // one signed product
  localparam int DW  = PW + 2;    // signed sum of three products
  localparam int DMW = DW - 1;    // magnitude of the sum

  // Magnitude of the dot product times the inverse, in two halves
  localparam int DLoW = 29;
  localparam int DHiW = DMW - DLoW;
  localparam int PLoW = DLoW + IKW;
  localparam int PHiW = DHiW + IKW;
  localparam int MW   = DMW + IKW;

  // Scaled dot product times |k|, in limbs
  localparam int LimbW    = 30;
  localparam int NumLimbs = (MW + LimbW - 1) / LimbW;
  localparam int MExtW    = LimbW * NumLimbs;
  localparam int KMW      = KW;
  localparam int LPW      = LimbW + KMW;
  localparam int CW       = LimbW * (NumLimbs - 1) + LPW;

  // Rounding and clamping of the correction term
  localparam int FracDrop = 48;                // 64 fraction bits down to 16
  localparam int RndBit   = FracDrop - 1;
  localparam int CapExp   = 34;                // correction is clamped to 2^34
  localparam int CapW     = CapExp + 1;
  localparam int SatBit   = FracDrop + CapExp;

  // Final difference before saturation
  localparam int SumW = CapW + 1;

  // Pipeline depth
  localparam int NumStages = 7;

  typedef struct packed {
    logic signed [KW-1:0]  wavenumber_x;
    logic signed [KW-1:0]  wavenumber_y;
    logic signed [KW-1:0]  wavenumber_z;
    logic        [IKW-1:0] inverse_k_squared;
    logic signed [QW-1:0]  field_x_real;
    logic signed [QW-1:0]  field_x_imag;
    logic signed [QW-1:0]  field_y_real;
    logic signed [QW-1:0]  field_y_imag;
    logic signed [QW-1:0]  field_z_real;
    logic signed [QW-1:0]  field_z_imag;
  } dfp_in_t;

  typedef struct packed {
    logic signed [QW-1:0] proj_x_real;
    logic signed [QW-1:0] proj_x_imag;
    logic signed [QW-1:0] proj_y_real;
    logic signed [QW-1:0] proj_y_imag;
    logic signed [QW-1:0] proj_z_real;
    logic signed [QW-1:0] proj_z_imag;
  } dfp_out_t;

endpackage

// ===== src/divergence_free_projector_core.sv =====
// Leray projection of one spectral mode per item, seven-stage pipeline; uses dfp_pkg.
// Throughput: one item per cycle; every stage holds one item and a full pipe stalls
// only while out_ready_i is low, with ready rippling back through the full stages.
// The widest step is the 29x32-bit partial product of |d| with the inverse.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module divergence_free_projector_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dfp_pkg::dfp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dfp_pkg::dfp_out_t out_data_o
);

  localparam int NS = dfp_pkg::NumStages;
  localparam int NC = dfp_pkg::NumComp;
  localparam int NP = dfp_pkg::NumPart;
  localparam int NL = dfp_pkg::NumLimbs;

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] stg_rdy;
  logic [NS-1:0] stg_ld;

  // A stage can take a new item when it is empty or its item moves on.
  always_comb begin
    stg_rdy[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      stg_rdy[s] = !valid_q[s] || stg_rdy[s+1];
    end
    valid_d[0] = stg_rdy[0] ? in_valid_i : valid_q[0];
    stg_ld[0]  = stg_rdy[0] && in_valid_i;
    for (int s = 1; s < NS; s++) begin
      valid_d[s] = stg_rdy[s] ? valid_q[s-1] : valid_q[s];
      stg_ld[s]  = stg_rdy[s] && valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stg_rdy[0];
  assign out_valid_o = valid_q[NS-1];

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  logic signed [dfp_pkg::KW-1:0] in_k   [NC];
  logic signed [dfp_pkg::QW-1:0] in_fld [NC][NP];

  always_comb begin
    in_k[0]      = in_data_i.wavenumber_x;
    in_k[1]      = in_data_i.wavenumber_y;
    in_k[2]      = in_data_i.wavenumber_z;
    in_fld[0][0] = in_data_i.field_x_real;
    in_fld[0][1] = in_data_i.field_x_imag;
    in_fld[1][0] = in_data_i.field_y_real;
    in_fld[1][1] = in_data_i.field_y_imag;
    in_fld[2][0] = in_data_i.field_z_real;
    in_fld[2][1] = in_data_i.field_z_imag;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: products k_c * q_c for the real and imaginary dot products
  // ---------------------------------------------------------------------------
  logic signed [dfp_pkg::PW-1:0]  s1_prod_d [NC][NP];
  logic signed [dfp_pkg::PW-1:0]  s1_prod_q [NC][NP];
  logic signed [dfp_pkg::KW-1:0]  s1_k_q    [NC];
  logic signed [dfp_pkg::QW-1:0]  s1_fld_q  [NC][NP];
  logic        [dfp_pkg::IKW-1:0] s1_ik_q;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int p = 0; p < NP; p++) begin
        s1_prod_d[c][p] = dfp_pkg::PW'(in_k[c]) * dfp_pkg::PW'(in_fld[c][p]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[0]) begin
      s1_prod_q <= s1_prod_d;
      s1_k_q    <= in_k;
      s1_fld_q  <= in_fld;
      s1_ik_q   <= in_data_i.inverse_k_squared;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: dot product sums, their magnitudes, |k| and the correction signs
  // ---------------------------------------------------------------------------
  logic signed [dfp_pkg::DW-1:0]  s2_dot      [NP];
  logic        [dfp_pkg::DMW-1:0] s2_dmag_d   [NP];
  logic        [dfp_pkg::KMW-1:0] s2_kmag_d   [NC];
  logic                           s2_neg_d    [NC][NP];
  logic        [dfp_pkg::DMW-1:0] s2_dmag_q   [NP];
  logic        [dfp_pkg::KMW-1:0] s2_kmag_q   [NC];
  logic                           s2_neg_q    [NC][NP];
  logic signed [dfp_pkg::QW-1:0]  s2_fld_q    [NC][NP];
  logic        [dfp_pkg::IKW-1:0] s2_ik_q;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      s2_dot[p] = dfp_pkg::DW'(s1_prod_q[0][p]) + dfp_pkg::DW'(s1_prod_q[1][p])
                + dfp_pkg::DW'(s1_prod_q[2][p]);
      if (s2_dot[p][dfp_pkg::DW-1]) begin
        s2_dmag_d[p] = dfp_pkg::DMW'(-s2_dot[p]);
      end else begin
        s2_dmag_d[p] = dfp_pkg::DMW'(s2_dot[p]);
      end
    end
    for (int c = 0; c < NC; c++) begin
      if (s1_k_q[c][dfp_pkg::KW-1]) begin
        s2_kmag_d[c] = dfp_pkg::KMW'(-s1_k_q[c]);
      end else begin
        s2_kmag_d[c] = dfp_pkg::KMW'(s1_k_q[c]);
      end
      for (int p = 0; p < NP; p++) begin
        s2_neg_d[c][p] = s1_k_q[c][dfp_pkg::KW-1] ^ s2_dot[p][dfp_pkg::DW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[1]) begin
      s2_dmag_q <= s2_dmag_d;
      s2_kmag_q <= s2_kmag_d;
      s2_neg_q  <= s2_neg_d;
      s2_fld_q  <= s1_fld_q;
      s2_ik_q   <= s1_ik_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: |d| times the inverse squared wavenumber, as two partial products
  // ---------------------------------------------------------------------------
  logic [dfp_pkg::PLoW-1:0]      s3_plo_d [NP];
  logic [dfp_pkg::PHiW-1:0]      s3_phi_d [NP];
  logic [dfp_pkg::PLoW-1:0]      s3_plo_q [NP];
  logic [dfp_pkg::PHiW-1:0]      s3_phi_q [NP];
  logic [dfp_pkg::KMW-1:0]       s3_kmag_q [NC];
  logic                          s3_neg_q  [NC][NP];
  logic signed [dfp_pkg::QW-1:0] s3_fld_q  [NC][NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      s3_plo_d[p] = dfp_pkg::PLoW'(s2_dmag_q[p][dfp_pkg::DLoW-1:0])
                  * dfp_pkg::PLoW'(s2_ik_q);
      s3_phi_d[p] = dfp_pkg::PHiW'(s2_dmag_q[p][dfp_pkg::DMW-1:dfp_pkg::DLoW])
                  * dfp_pkg::PHiW'(s2_ik_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[2]) begin
      s3_plo_q  <= s3_plo_d;
      s3_phi_q  <= s3_phi_d;
      s3_kmag_q <= s2_kmag_q;
      s3_neg_q  <= s2_neg_q;
      s3_fld_q  <= s2_fld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: combine the partial products into the scaled dot product
  // ---------------------------------------------------------------------------
  logic [dfp_pkg::MW-1:0]        s4_m_d    [NP];
  logic [dfp_pkg::MW-1:0]        s4_m_q    [NP];
  logic [dfp_pkg::KMW-1:0]       s4_kmag_q [NC];
  logic                          s4_neg_q  [NC][NP];
  logic signed [dfp_pkg::QW-1:0] s4_fld_q  [NC][NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      s4_m_d[p] = dfp_pkg::MW'(s3_plo_q[p])
                + (dfp_pkg::MW'(s3_phi_q[p]) << dfp_pkg::DLoW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[3]) begin
      s4_m_q    <= s4_m_d;
      s4_kmag_q <= s3_kmag_q;
      s4_neg_q  <= s3_neg_q;
      s4_fld_q  <= s3_fld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: limb products of the scaled dot product with |k_c|
  // ---------------------------------------------------------------------------
  logic [dfp_pkg::MExtW-1:0]     s5_mext   [NP];
  logic [dfp_pkg::LPW-1:0]       s5_cp_d   [NC][NP][NL];
  logic [dfp_pkg::LPW-1:0]       s5_cp_q   [NC][NP][NL];
  logic                          s5_neg_q  [NC][NP];
  logic signed [dfp_pkg::QW-1:0] s5_fld_q  [NC][NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      s5_mext[p] = dfp_pkg::MExtW'(s4_m_q[p]);
    end
    for (int c = 0; c < NC; c++) begin
      for (int p = 0; p < NP; p++) begin
        for (int j = 0; j < NL; j++) begin
          s5_cp_d[c][p][j] =
            dfp_pkg::LPW'(s5_mext[p][j*dfp_pkg::LimbW +: dfp_pkg::LimbW])
            * dfp_pkg::LPW'(s4_kmag_q[c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[4]) begin
      s5_cp_q  <= s5_cp_d;
      s5_neg_q <= s4_neg_q;
      s5_fld_q <= s4_fld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: sum the limbs, round half up at bit 48, clamp the magnitude
  // ---------------------------------------------------------------------------
  logic [dfp_pkg::CW-1:0]        s6_corr  [NC][NP];
  logic [dfp_pkg::CapW-1:0]      s6_mag_d [NC][NP];
  logic [dfp_pkg::CapW-1:0]      s6_mag_q [NC][NP];
  logic                          s6_neg_q [NC][NP];
  logic signed [dfp_pkg::QW-1:0] s6_fld_q [NC][NP];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int p = 0; p < NP; p++) begin
        s6_corr[c][p] = dfp_pkg::CW'(1) << dfp_pkg::RndBit;
        for (int j = 0; j < NL; j++) begin
          s6_corr[c][p] = s6_corr[c][p]
                        + (dfp_pkg::CW'(s5_cp_q[c][p][j]) << (j * dfp_pkg::LimbW));
        end
        if (|s6_corr[c][p][dfp_pkg::CW-1:dfp_pkg::SatBit]) begin
          s6_mag_d[c][p] = dfp_pkg::CapW'(1) << dfp_pkg::CapExp;
        end else begin
          s6_mag_d[c][p] = {1'b0, s6_corr[c][p][dfp_pkg::SatBit-1:dfp_pkg::FracDrop]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[5]) begin
      s6_mag_q <= s6_mag_d;
      s6_neg_q <= s5_neg_q;
      s6_fld_q <= s5_fld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: apply the correction to the field and saturate to 32 bits
  // ---------------------------------------------------------------------------
  logic signed [dfp_pkg::SumW-1:0] s7_ext_q [NC][NP];
  logic signed [dfp_pkg::SumW-1:0] s7_ext_m [NC][NP];
  logic signed [dfp_pkg::SumW-1:0] s7_sum   [NC][NP];
  logic        [dfp_pkg::QW-1:0]   s7_res_d [NC][NP];
  dfp_pkg::dfp_out_t               out_d, out_q;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int p = 0; p < NP; p++) begin
        s7_ext_q[c][p] = dfp_pkg::SumW'(s6_fld_q[c][p]);
        s7_ext_m[c][p] = dfp_pkg::SumW'(s6_mag_q[c][p]);
        if (s6_neg_q[c][p]) begin
          s7_sum[c][p] = s7_ext_q[c][p] + s7_ext_m[c][p];
        end else begin
          s7_sum[c][p] = s7_ext_q[c][p] - s7_ext_m[c][p];
        end
        // The top bits must all match the sign, else the result is clamped.
        if ((s7_sum[c][p][dfp_pkg::SumW-1:dfp_pkg::QW-1] != '0) &&
            (s7_sum[c][p][dfp_pkg::SumW-1:dfp_pkg::QW-1] != '1)) begin
          s7_res_d[c][p] = s7_sum[c][p][dfp_pkg::SumW-1]
                         ? {1'b1, {(dfp_pkg::QW-1){1'b0}}}
                         : {1'b0, {(dfp_pkg::QW-1){1'b1}}};
        end else begin
          s7_res_d[c][p] = s7_sum[c][p][dfp_pkg::QW-1:0];
        end
      end
    end
    out_d.proj_x_real = s7_res_d[0][0];
    out_d.proj_x_imag = s7_res_d[0][1];
    out_d.proj_y_real = s7_res_d[1][0];
    out_d.proj_y_imag = s7_res_d[1][1];
    out_d.proj_z_real = s7_res_d[2][0];
    out_d.proj_z_imag = s7_res_d[2][1];
  end

  always_ff @(posedge clk_i) begin
    if (stg_ld[6]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Input back-pressure only happens when every stage is full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&valid_q) && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // A stage that holds an item and cannot pass it on keeps it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_q & ~stg_rdy) != '0) |=> ((($past(valid_q) & ~$past(stg_rdy)) & ~valid_q) == '0))
    else $error("a stalled stage dropped its item");

  // The clamped correction never exceeds the cap.
  for (genvar gc = 0; gc < NC; gc++) begin : g_cap_c
    for (genvar gp = 0; gp < NP; gp++) begin : g_cap_p
      assert property (@(posedge clk_i) disable iff (!rst_ni)
        valid_q[5] |-> (s6_mag_q[gc][gp] <= (dfp_pkg::CapW'(1) << dfp_pkg::CapExp)))
        else $error("correction magnitude above the cap");
    end
  end

endmodule
